### rtl/qcot_pkg.sv
package qcot_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 15;
    localparam int CFG_IDX_BITS = 1;
    localparam int PT_BITS    = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_coord cell_low_x;
        t_coord cell_low_y;
        t_coord vertex0_x;
        t_coord vertex0_y;
        t_coord vertex1_x;
        t_coord vertex1_y;
        t_coord vertex2_x;
        t_coord vertex2_y;
        t_coord vertex3_x;
        t_coord vertex3_y;
    } t_in;

    typedef struct packed {
        logic vertex_inside;
        logic edge_crossing;
        logic overlaps;
    } t_out;

endpackage

### rtl/quad_cell_overlap_test_top.sv
// Cell / quadrilateral overlap test.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat carries the
// lower-left corner of an axis-aligned cell and the four quad vertices.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per input
// beat, in order, with vertex_inside, edge_crossing and overlaps.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data): index 0 sets the cell
// width, index 1 the cell height; write only while no beat is in flight.
// A beat accepted into the input register goes through the result register
// to the output. Throughput: one beat per cycle while the receiver takes
// results; the vertex-inside compares, the 16 cell-corner cross products (one
// multiplier level) and the orientation logic sit between the two registers.
// Reset clears both valid flags and sets width and height to 1024.
// When the receiver stalls, the result register holds and the input
// register keeps taking one more beat; after that o_in_ready drops until
// the output is taken. o_in_ready follows i_out_ready in the same cycle.
module quad_cell_overlap_test_top
    import qcot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in                     i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out                    o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    localparam int PW = PT_BITS;
    localparam int DW = PW + 1;
    localparam int QW = COORD_BITS + 1;
    localparam int MW = QW + DW;
    localparam int CW = MW + 1;
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(1024);
    localparam logic [3:0] CORNER_XI = 4'b1100;
    localparam logic [3:0] CORNER_YI = 4'b0110;

    typedef struct packed {
        logic neg;
        logic pos;
    } t_sgn;

    localparam t_sgn SGN_ZERO = '{neg: 1'b0, pos: 1'b0};

    function automatic t_sgn sgn_flip(input t_sgn s);
        return '{neg: s.pos, pos: s.neg};
    endfunction

    function automatic logic sgn_zero(input t_sgn s);
        return !(s.neg || s.pos);
    endfunction

    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;
    logic                r_in_valid;
    t_in                 r_in;
    logic                r_out_valid;
    t_out                r_out;

    logic n_in_valid;
    logic n_out_valid;
    t_out n_out;
    logic in_fire;
    logic out_adv;

    logic signed [PW-1:0] x_pt [2];
    logic signed [PW-1:0] y_pt [2];
    t_coord               vx [4];
    t_coord               vy [4];
    logic signed [DW-1:0] dxv [4][2];
    logic signed [DW-1:0] dyv [4][2];
    t_sgn                 sx [4][2];
    t_sgn                 sy [4][2];
    logic signed [QW-1:0] dqx [4];
    logic signed [QW-1:0] dqy [4];
    logic signed [MW-1:0] prod_p [4][2];
    logic signed [MW-1:0] prod_q [4][2];
    logic signed [CW-1:0] crs [4][4];
    t_sgn                 sc [4][4];
    t_sgn                 se [4][4];
    logic                 win_ce [4][4];
    logic                 win_qc [4][4];
    logic                 w_nz;
    logic                 h_nz;
    logic                 vtx_hit;
    logic                 crossing;

    assign out_adv    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    assign vx[0] = r_in.vertex0_x;
    assign vy[0] = r_in.vertex0_y;
    assign vx[1] = r_in.vertex1_x;
    assign vy[1] = r_in.vertex1_y;
    assign vx[2] = r_in.vertex2_x;
    assign vy[2] = r_in.vertex2_y;
    assign vx[3] = r_in.vertex3_x;
    assign vy[3] = r_in.vertex3_y;

    assign x_pt[0] = PW'(r_in.cell_low_x);
    assign y_pt[0] = PW'(r_in.cell_low_y);
    assign x_pt[1] = x_pt[0] + PW'($signed({1'b0, r_width}));
    assign y_pt[1] = y_pt[0] + PW'($signed({1'b0, r_height}));
    assign w_nz    = |r_width;
    assign h_nz    = |r_height;

    // vertex against cell bounds
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            for (int b = 0; b < 2; b++) begin
                dxv[m][b]    = DW'(vx[m]) - DW'(x_pt[b]);
                dyv[m][b]    = DW'(vy[m]) - DW'(y_pt[b]);
                sx[m][b].neg = dxv[m][b][DW-1];
                sx[m][b].pos = !dxv[m][b][DW-1] && (|dxv[m][b]);
                sy[m][b].neg = dyv[m][b][DW-1];
                sy[m][b].pos = !dyv[m][b][DW-1] && (|dyv[m][b]);
            end
        end
    end

    // cell corners against quad edges
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            dqx[j] = QW'(vx[(j + 1) % 4]) - QW'(vx[j]);
            dqy[j] = QW'(vy[(j + 1) % 4]) - QW'(vy[j]);
            for (int b = 0; b < 2; b++) begin
                prod_p[j][b] = MW'(dqy[j]) * MW'(dxv[(j + 1) % 4][b]);
                prod_q[j][b] = MW'(dqx[j]) * MW'(dyv[(j + 1) % 4][b]);
            end
            for (int k = 0; k < 4; k++) begin
                crs[j][k]    = CW'(prod_q[j][CORNER_YI[k]]) - CW'(prod_p[j][CORNER_XI[k]]);
                sc[j][k].neg = crs[j][k][CW-1];
                sc[j][k].pos = !crs[j][k][CW-1] && (|crs[j][k]);
            end
        end
    end

    // quad vertices against cell edges
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int m = 0; m < 4; m++) begin
                case (i)
                    0:       se[i][m] = h_nz ? sx[m][0] : SGN_ZERO;
                    1:       se[i][m] = w_nz ? sgn_flip(sy[m][1]) : SGN_ZERO;
                    2:       se[i][m] = h_nz ? sgn_flip(sx[m][1]) : SGN_ZERO;
                    default: se[i][m] = w_nz ? sy[m][0] : SGN_ZERO;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int m = 0; m < 4; m++) begin
                win_ce[i][m] =
                    !sx[m][CORNER_XI[i] & CORNER_XI[(i + 1) % 4]].neg &&
                    !sx[m][CORNER_XI[i] | CORNER_XI[(i + 1) % 4]].pos &&
                    !sy[m][CORNER_YI[i] & CORNER_YI[(i + 1) % 4]].neg &&
                    !sy[m][CORNER_YI[i] | CORNER_YI[(i + 1) % 4]].pos;
            end
        end
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
                win_qc[j][k] =
                    (!sx[j][CORNER_XI[k]].neg || !sx[(j + 1) % 4][CORNER_XI[k]].neg) &&
                    (!sx[j][CORNER_XI[k]].pos || !sx[(j + 1) % 4][CORNER_XI[k]].pos) &&
                    (!sy[j][CORNER_YI[k]].neg || !sy[(j + 1) % 4][CORNER_YI[k]].neg) &&
                    (!sy[j][CORNER_YI[k]].pos || !sy[(j + 1) % 4][CORNER_YI[k]].pos);
            end
        end
    end

    always_comb begin
        vtx_hit  = 1'b0;
        crossing = 1'b0;
        for (int m = 0; m < 4; m++) begin
            if (sx[m][0].pos && sx[m][1].neg && sy[m][0].pos && sy[m][1].neg) begin
                vtx_hit = 1'b1;
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (((se[i][j] != se[i][(j + 1) % 4]) &&
                     (sc[j][i] != sc[j][(i + 1) % 4])) ||
                    (sgn_zero(se[i][j]) && win_ce[i][j]) ||
                    (sgn_zero(se[i][(j + 1) % 4]) && win_ce[i][(j + 1) % 4]) ||
                    (sgn_zero(sc[j][i]) && win_qc[j][i]) ||
                    (sgn_zero(sc[j][(i + 1) % 4]) && win_qc[j][(i + 1) % 4])) begin
                    crossing = 1'b1;
                end
            end
        end
        n_out.vertex_inside = vtx_hit;
        n_out.edge_crossing = crossing;
        n_out.overlaps      = vtx_hit || crossing;
    end

    always_comb begin
        n_in_valid  = in_fire ? 1'b1 : (out_adv ? 1'b0 : r_in_valid);
        n_out_valid = out_adv ? r_in_valid : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= CFG_RESET;
            r_height    <= CFG_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        if (r_in_valid && out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/qcot_chk.sv
module qcot_chk
    import qcot_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input t_in                     i_in_data,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input t_out                    o_out_data,
    input logic                    i_cfg_we,
    input logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input logic [CFG_BITS-1:0]     i_cfg_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("accepted beat did not reach output");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output free");

    a_overlap_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.overlaps ==
                         (o_out_data.vertex_inside || o_out_data.edge_crossing)))
        else $error("overlap flag inconsistent");

endmodule

bind quad_cell_overlap_test_top qcot_chk u_qcot_chk (.*);

### dv/quad_cell_overlap_checker.sv
module quad_cell_overlap_checker
    import qcot_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_in                     i_in_data,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  t_out                    i_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_overlap_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint x;
        longint y;
    } t_pt;

    longint cell_w;
    longint cell_h;
    t_out   verdict_q[$];
    t_out   want;
    bit     bad;

    function automatic int turn_dir(t_pt p, t_pt q, t_pt r);
        longint s;
        s = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
        if (s == 0) return 0;
        return (s > 0) ? 1 : 2;
    endfunction

    function automatic bit in_box(t_pt p, t_pt q, t_pt r);
        longint xmax, xmin, ymax, ymin;
        xmax = (p.x > r.x) ? p.x : r.x;
        xmin = (p.x < r.x) ? p.x : r.x;
        ymax = (p.y > r.y) ? p.y : r.y;
        ymin = (p.y < r.y) ? p.y : r.y;
        return q.x <= xmax && q.x >= xmin && q.y <= ymax && q.y >= ymin;
    endfunction

    function automatic bit segments_meet(t_pt a1, t_pt a2, t_pt b1, t_pt b2);
        int o1, o2, o3, o4;
        o1 = turn_dir(a1, a2, b1);
        o2 = turn_dir(a1, a2, b2);
        o3 = turn_dir(b1, b2, a1);
        o4 = turn_dir(b1, b2, a2);
        if (o1 != o2 && o3 != o4) return 1'b1;
        if (o1 == 0 && in_box(a1, b1, a2)) return 1'b1;
        if (o2 == 0 && in_box(a1, b2, a2)) return 1'b1;
        if (o3 == 0 && in_box(b1, a1, b2)) return 1'b1;
        if (o4 == 0 && in_box(b1, a2, b2)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_out predict_overlap(t_in d);
        t_pt    corner[4];
        t_pt    vert[4];
        longint lx, ly, hx, hy;
        t_out   r;
        lx = longint'(d.cell_low_x);
        ly = longint'(d.cell_low_y);
        hx = lx + cell_w;
        hy = ly + cell_h;
        corner[0] = '{lx, ly};
        corner[1] = '{lx, hy};
        corner[2] = '{hx, hy};
        corner[3] = '{hx, ly};
        vert[0] = '{longint'(d.vertex0_x), longint'(d.vertex0_y)};
        vert[1] = '{longint'(d.vertex1_x), longint'(d.vertex1_y)};
        vert[2] = '{longint'(d.vertex2_x), longint'(d.vertex2_y)};
        vert[3] = '{longint'(d.vertex3_x), longint'(d.vertex3_y)};
        r = '0;
        for (int j = 0; j < 4; j++) begin
            if (vert[j].x > lx && vert[j].x < hx && vert[j].y > ly && vert[j].y < hy)
                r.vertex_inside = 1'b1;
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (segments_meet(corner[i], corner[(i + 1) % 4], vert[j], vert[(j + 1) % 4]))
                    r.edge_crossing = 1'b1;
            end
        end
        r.overlaps = r.vertex_inside | r.edge_crossing;
        return r;
    endfunction

    task automatic check_bit(input string name, input logic exp_b, input logic got_b,
                             inout bit flag);
        if (got_b !== exp_b) begin
            $error("%s: expected %0b, got %0b", name, exp_b, got_b);
            flag = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_w = 1024;
            cell_h = 1024;
            verdict_q.delete();
            o_fail_count = 0;
            o_results = 0;
            o_overlap_hits = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no expectation pending: %b", i_out_data);
                    o_fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    bad = 1'b0;
                    check_bit("vertex_inside", want.vertex_inside,
                              i_out_data.vertex_inside, bad);
                    check_bit("edge_crossing", want.edge_crossing,
                              i_out_data.edge_crossing, bad);
                    check_bit("overlaps", want.overlaps, i_out_data.overlaps, bad);
                    if (bad) o_fail_count++;
                    o_results++;
                    if (want.overlaps) o_overlap_hits++;
                end
            end
            if (i_in_valid && i_in_ready)
                verdict_q = {verdict_q, predict_overlap(i_in_data)};
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIDTH: begin
                        cell_w = longint'(i_cfg_data);
                    end
                    CFG_HEIGHT: begin
                        cell_h = longint'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

### dv/tb_quad_cell_overlap_test_top.sv
module tb_quad_cell_overlap_test_top
    import qcot_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PHASES       = 8;
    localparam int BEATS_PER_PHASE = 215;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    t_in                     i_in_data;
    logic                    o_out_valid;
    logic                    i_out_ready;
    t_out                    o_out_data;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int results;
    int overlap_hits;
    int sender_idle_pct;
    int rx_stall_pct;
    bit rx_hold_req;
    int cur_w;
    int cur_h;
    int size_w[N_PHASES];
    int size_h[N_PHASES];
    int idle_tab[N_PHASES];
    int stall_tab[N_PHASES];

    quad_cell_overlap_test_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    quad_cell_overlap_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (results),
        .o_overlap_hits (overlap_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_coord clip(int v);
        if (v > 32767) return t_coord'(32767);
        if (v < -32768) return t_coord'(-32768);
        return t_coord'(v);
    endfunction

    function automatic t_in quad(int lx, int ly, int x0, int y0, int x1, int y1,
                                 int x2, int y2, int x3, int y3);
        return '{clip(lx), clip(ly), clip(x0), clip(y0), clip(x1), clip(y1),
                 clip(x2), clip(y2), clip(x3), clip(y3)};
    endfunction

    function automatic int near_edge(int lo, int span);
        case ($urandom_range(6))
            0: return lo;
            1: return lo + span;
            2, 3: return lo + int'($urandom_range(span));
            4: return lo - 1 - int'($urandom_range(99));
            5: return lo + span + 1 + int'($urandom_range(99));
            default: return lo - int'($urandom_range(span)) + int'($urandom_range(2 * span));
        endcase
    endfunction

    function automatic int pick_low(int span);
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767 - int'($urandom_range(span));
            default: return int'(t_coord'($urandom));
        endcase
    endfunction

    function automatic t_in cell_case(int w, int h);
        int lx, ly;
        int xs[4];
        int ys[4];
        if ($urandom_range(9) < 2)
            return t_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        lx = pick_low(w);
        ly = pick_low(h);
        for (int j = 0; j < 4; j++) begin
            xs[j] = near_edge(lx, w);
            ys[j] = near_edge(ly, h);
            if (j > 0 && $urandom_range(7) == 0) begin
                xs[j] = xs[j - 1];
                ys[j] = ys[j - 1];
            end
        end
        return quad(lx, ly, xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3]);
    endfunction

    task automatic send_beat(input t_in d);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic set_cell_size(input int w, input int h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WIDTH;
        i_cfg_data <= CFG_BITS'(w);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_HEIGHT;
        i_cfg_data <= CFG_BITS'(h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_w = w;
        cur_h = h;
        @(negedge i_clk);
    endtask

    task automatic run_directed();
        // inside only, disjoint, enclosing, touching, crossing
        send_beat(quad(0, 0, 100, 100, 200, 100, 200, 200, 100, 200));
        send_beat(quad(0, 0, 2000, 2000, 3000, 2000, 3000, 3000, 2000, 3000));
        send_beat(quad(0, 0, -5000, -5000, 5000, -5000, 5000, 5000, -5000, 5000));
        send_beat(quad(0, 0, 1024, 500, 2000, 500, 2000, 600, 1024, 600));
        send_beat(quad(0, 0, -100, 512, 2000, 512, 2000, 520, -100, 520));
        // degenerate quads collapsed to a point
        send_beat(quad(0, 0, 5, 5, 5, 5, 5, 5, 5, 5));
        send_beat(quad(0, 0, 1024, 1024, 1024, 1024, 1024, 1024, 1024, 1024));
        send_beat(quad(0, 0, -1, -1, -1, -1, -1, -1, -1, -1));
        // collinear overlap and collinear miss along the bottom edge
        send_beat(quad(0, 0, -50, 0, 50, 0, 50, -10, -50, -10));
        send_beat(quad(0, 0, 2000, 0, 3000, 0, 3000, -10, 2000, -10));
        // coordinate extremes, upper cell corner past the coordinate range
        send_beat(quad(32767, 32767, 32767, 32767, -32768, -32768, 32767, -32768,
                       -32768, 32767));
        send_beat(quad(-32768, -32768, -32767, -32767, -32767, -32767, -32767, -32767,
                       -32767, -32767));
        send_beat(quad(0, 0, 32767, 32767, -32768, 32767, -32768, -32768, 32767, -32768));
        send_beat(quad(32767, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                       -32768, -32768));
        send_beat(quad(0, 0, 1023, 1023, 3000, 3000, 3000, 3000, 1023, 1023));
        send_beat(quad(0, 0, -10, 1034, 1034, -10, 1034, -10, -10, 1034));
        send_beat(quad(0, 0, 1024, 1024, 1100, 1100, 1100, 1200, 1024, 1100));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_WIDTH;
        i_cfg_data      = '0;
        sender_idle_pct = 0;
        rx_stall_pct    = 0;
        rx_hold_req     = 1'b0;
        cur_w           = 1024;
        cur_h           = 1024;
        size_w    = '{1024, 0, 32767, 0, 32767, int'($urandom_range(64, 1)), 1,
                      int'($urandom_range(32767))};
        size_h    = '{1024, 0, 32767, 777, 1, int'($urandom_range(64, 1)), 0,
                      int'($urandom_range(32767))};
        idle_tab  = '{0, 83, 0, 9, 0, 83, 0, 9};
        stall_tab = '{0, 0, 83, 9, 0, 0, 83, 9};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain();
                set_cell_size(size_w[p], size_h[p]);
            end
            sender_idle_pct = idle_tab[p];
            rx_stall_pct    = stall_tab[p];
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                if (k == 40) rx_hold_req = 1'b1;
                if (k == 120) drain();
                send_beat(cell_case(cur_w, cur_h));
            end
        end
        drain();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d result beats (%0d overlapping) over %0d cell sizes,",
                 results, overlap_hits, N_PHASES);
        $display("zero and full-scale extents, point-like quads and all idle/stall mixes.");
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
